// ===== rtl/sba_pkg.sv =====
// Package for the slab bitmap allocator: widths, codes, defaults and state type.
package sba_pkg;

  localparam int ADDR_W         = 48;
  localparam int OSIZE_W        = 16;
  localparam int OPB_W          = 9;
  localparam int MODE_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int WORD_W         = 64;

  localparam int MASK_WORDS_DEF = 4;
  localparam int MAX_SLABS_DEF  = 8;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [OSIZE_W-1:0] OSIZE_RST = 16'd64;
  localparam logic [OPB_W-1:0]   OPB_RST   = 9'd256;
  localparam logic [ADDR_W-1:0]  BASE_RST  = 48'd0;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OSIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_PREP2,
    S_A_CRD,
    S_A_CCHK,
    S_A_ACT,
    S_A_WRD,
    S_A_WCHK,
    S_A_MUL,
    S_A_SUM,
    S_F_START1,
    S_F_DIV1,
    S_F_START2,
    S_F_DIV2,
    S_F_RD,
    S_DONE
  } sba_state_t;

endpackage

// ===== rtl/sba_in_if.sv =====
// Request channel: mode and address with valid/ready.
interface sba_in_if;
  import sba_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ADDR_W-1:0]   address;
  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

// ===== rtl/sba_out_if.sv =====
// Result channel: status and allocated address with valid/ready.
interface sba_out_if;
  import sba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_address;
  modport source (output valid, output status, output result_address, input ready);
  modport sink   (input valid, input status, input result_address, output ready);
endinterface

// ===== rtl/sba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sba_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sba_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sba_pkg::ADDR_W-1:0] dvd,
  input  logic [sba_pkg::ADDR_W-1:0] dvs,
  output logic                      done,
  output logic [sba_pkg::ADDR_W-1:0] quo,
  output logic [sba_pkg::ADDR_W-1:0] rem
);
  import sba_pkg::*;
  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic [ADDR_W-1:0] dvs_r, dvs_nxt;
  logic [ADDR_W:0]   sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r, quo_r[ADDR_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dvd;
      rem_nxt  = '0;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = ADDR_W'(sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[ADDR_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// ===== rtl/slab_bitmap_allocator_unit.sv =====
// Top level of the slab bitmap allocator: sequencer, config registers, memories.
//
//  channel   dir  handshake      payload
//  in_if     in   valid/ready    mode[1:0], address[47:0]
//  out_if    out  valid/ready    status[1:0], result_address[47:0]
//  cfg_*     in   cfg_we only    cfg_index[1:0], cfg_wdata[47:0]
//
// One item at a time. Allocate scans the slab counts, activates a slab by clearing
// its MASK_WORDS bitmap words if no slab has room, then scans the bitmap words.
// Free uses the bit-serial divider twice, for slab and slot, then clears the bit.
// Clear empties the pool. Sync reset empties the pool at once; no sweep.
// A waiting result does not block the next item; a stalled output holds in DONE.
module slab_bitmap_allocator_unit #(
  parameter int MASK_WORDS = sba_pkg::MASK_WORDS_DEF,
  parameter int MAX_SLABS  = sba_pkg::MAX_SLABS_DEF,
  parameter int PAGE_BYTES = sba_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sba_in_if.sink                       in_if,
  sba_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sba_pkg::ADDR_W-1:0]    cfg_wdata
);
  import sba_pkg::*;

  localparam int WCW = $clog2(MASK_WORDS + 1);
  localparam int NW  = WCW + 6;
  localparam int SW  = OSIZE_W + NW + 1;
  localparam int ACW = $clog2(MAX_SLABS + 1);
  localparam int SLW = MAX_SLABS > 1 ? $clog2(MAX_SLABS) : 1;
  localparam int BD  = MAX_SLABS * MASK_WORDS;
  localparam int AW  = BD > 1 ? $clog2(BD) : 1;
  localparam int M1W = SW + SLW;
  localparam int M2W = OSIZE_W + NW;

  sba_state_t state_r, state_nxt;

  logic [OSIZE_W-1:0] os_r;
  logic [OPB_W-1:0]   opb_r;
  logic [ADDR_W-1:0]  base_r;

  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [WCW-1:0]      words_r, words_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [SW-1:0]       prod_r, prod_nxt;
  logic [SW-1:0]       stride_r, stride_nxt;
  logic [ACW-1:0]      s_r, s_nxt;
  logic [WCW-1:0]      w_r, w_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [NW-1:0]       slot_r, slot_nxt;
  logic [SLW-1:0]      slab_r, slab_nxt;
  logic [ACW-1:0]      active_r, active_nxt;
  logic [M1W-1:0]      m1_r, m1_nxt;
  logic [M2W-1:0]      m2_r, m2_nxt;
  logic [ADDR_W-1:0]   res_r, res_nxt;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  logic              bm_we;
  logic [AW-1:0]     bm_waddr, bm_raddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  logic              cnt_we;
  logic [SLW-1:0]    cnt_waddr, cnt_raddr;
  logic [NW-1:0]     cnt_wdata, cnt_rdata;

  logic              div_start, div_done;
  logic [ADDR_W-1:0] div_dvd, div_dvs, div_quo, div_rem;

  logic              in_acc, out_ld;
  logic [3:0]        wreq;
  logic [WCW-1:0]    words_c;
  logic [NW-1:0]     n_c;
  logic              alloc_bad;
  logic              pool_full;
  logic              word_full;
  logic [WORD_W-1:0] inv, low;
  logic [5:0]        bidx;
  logic [AW-1:0]     a_addr, f_addr;
  logic              f_bit;

  function automatic logic [AW-1:0] bm_addr(input logic [SLW-1:0] slab,
                                            input logic [WCW-1:0] word);
    bm_addr = AW'(slab) * AW'(MASK_WORDS) + AW'(word);
  endfunction

  // objects per slab rounded up to whole words and capped
  assign wreq    = 4'((10'(opb_r) + 10'd63) >> 6);
  assign words_c = (5'(wreq) > 5'(MASK_WORDS)) ? WCW'(MASK_WORDS) : WCW'(wreq);
  assign n_c     = {words_c, 6'b0};

  assign alloc_bad = (words_r == '0) || (os_r == '0);
  assign pool_full = (s_r == active_r) && (active_r >= ACW'(MAX_SLABS));
  assign word_full = (bm_rdata == '1);
  assign inv       = ~bm_rdata;
  assign low       = inv & (~inv + 64'd1);
  assign a_addr    = bm_addr(s_r[SLW-1:0], w_r);
  assign f_addr    = bm_addr(slab_r, slot_r[NW-1:6]);
  assign f_bit     = bm_rdata[slot_r[5:0]];

  always_comb begin
    bidx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low[i]) begin
        bidx = bidx | 6'(i);
      end
    end
  end

  assign in_if.ready    = (state_r == S_IDLE);
  assign in_acc         = in_if.valid && in_if.ready;
  assign out_ld         = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign out_if.valid   = out_valid_r;
  assign out_if.status  = out_status_r;
  assign out_if.result_address = out_addr_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_PREP2;
      S_PREP2: begin
        priority if (mode_r == MODE_ALLOC) begin
          state_nxt = alloc_bad ? S_DONE : S_A_CRD;
        end else if (mode_r == MODE_FREE) begin
          state_nxt = alloc_bad ? S_DONE : S_F_START1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_A_CRD: begin
        priority if (pool_full) state_nxt = S_DONE;
        else if (s_r == active_r) state_nxt = S_A_ACT;
        else state_nxt = S_A_CCHK;
      end
      S_A_CCHK: state_nxt = (cnt_rdata < n_r) ? S_A_WRD : S_A_CRD;
      S_A_ACT:  if (w_r == WCW'(MASK_WORDS - 1)) state_nxt = S_A_WRD;
      S_A_WRD:  state_nxt = (w_r == words_r) ? S_DONE : S_A_WCHK;
      S_A_WCHK: state_nxt = word_full ? S_A_WRD : S_A_MUL;
      S_A_MUL:  state_nxt = S_A_SUM;
      S_A_SUM:  state_nxt = S_DONE;
      S_F_START1: state_nxt = S_F_DIV1;
      S_F_DIV1: begin
        if (div_done) begin
          state_nxt = (div_quo >= ADDR_W'(active_r)) ? S_DONE : S_F_START2;
        end
      end
      S_F_START2: state_nxt = S_F_DIV2;
      S_F_DIV2: begin
        if (div_done) begin
          state_nxt = ((div_rem != '0) || (div_quo >= ADDR_W'(n_r))) ? S_DONE : S_F_RD;
        end
      end
      S_F_RD: state_nxt = S_DONE;
      S_DONE: if (out_ld) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = a_addr;
    bm_wdata  = '0;
    bm_raddr  = a_addr;
    cnt_we    = 1'b0;
    cnt_waddr = s_r[SLW-1:0];
    cnt_wdata = '0;
    cnt_raddr = s_r[SLW-1:0];
    div_start = 1'b0;
    div_dvd   = addr_r - base_r;
    div_dvs   = ADDR_W'(stride_r);
    unique case (state_r)
      S_A_ACT: begin
        bm_we  = 1'b1;
        cnt_we = (w_r == '0);
      end
      S_A_WCHK: begin
        if (!word_full) begin
          bm_we     = 1'b1;
          bm_wdata  = bm_rdata | low;
          cnt_we    = 1'b1;
          cnt_wdata = cnt_r + NW'(1);
        end
      end
      S_F_START1: div_start = 1'b1;
      S_F_START2: begin
        div_start = 1'b1;
        div_dvd   = div_rem;
        div_dvs   = ADDR_W'(os_r);
      end
      S_F_DIV2: begin
        // fetch word and count for the slot the divider is about to give
        bm_raddr  = bm_addr(slab_r, div_quo[NW-1:6]);
        cnt_raddr = slab_r;
      end
      S_F_RD: begin
        bm_raddr  = f_addr;
        cnt_raddr = slab_r;
        bm_waddr  = f_addr;
        cnt_waddr = slab_r;
        if (f_bit) begin
          bm_we     = 1'b1;
          bm_wdata  = bm_rdata & ~(64'd1 << slot_r[5:0]);
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata - NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    words_nxt      = words_r;
    n_nxt          = n_r;
    prod_nxt       = prod_r;
    stride_nxt     = stride_r;
    s_nxt          = s_r;
    w_nxt          = w_r;
    cnt_nxt        = cnt_r;
    slot_nxt       = slot_r;
    slab_nxt       = slab_r;
    active_nxt     = active_r;
    m1_nxt         = m1_r;
    m2_nxt         = m2_r;
    res_nxt        = res_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_if.mode;
          addr_nxt = in_if.address;
          res_nxt  = '0;
          stat_nxt = ST_OK;
        end
      end
      S_PREP: begin
        words_nxt = words_c;
        n_nxt     = n_c;
        prod_nxt  = SW'(os_r) * SW'(n_c);
      end
      S_PREP2: begin
        stride_nxt = (prod_r + SW'(PAGE_BYTES - 1)) & ~SW'(PAGE_BYTES - 1);
        s_nxt      = '0;
        if (mode_r == MODE_ALLOC && alloc_bad) stat_nxt = ST_NOSPACE;
        if (mode_r == MODE_FREE && alloc_bad)  stat_nxt = ST_IGNORED;
        if (mode_r == MODE_CLEAR)              active_nxt = '0;
      end
      S_A_CRD: begin
        if (pool_full) stat_nxt = ST_NOSPACE;
        w_nxt = '0;
      end
      S_A_CCHK: begin
        if (cnt_rdata < n_r) begin
          cnt_nxt = cnt_rdata;
          w_nxt   = '0;
        end else begin
          s_nxt = s_r + ACW'(1);
        end
      end
      S_A_ACT: begin
        w_nxt = w_r + WCW'(1);
        if (w_r == WCW'(MASK_WORDS - 1)) begin
          active_nxt = active_r + ACW'(1);
          cnt_nxt    = '0;
          w_nxt      = '0;
        end
      end
      S_A_WRD: if (w_r == words_r) stat_nxt = ST_NOSPACE;
      S_A_WCHK: begin
        if (word_full) w_nxt = w_r + WCW'(1);
        else slot_nxt = {w_r, bidx};
      end
      S_A_MUL: begin
        m1_nxt = M1W'(s_r[SLW-1:0]) * M1W'(stride_r);
        m2_nxt = M2W'(os_r) * M2W'(slot_r);
      end
      S_A_SUM: res_nxt = base_r + ADDR_W'(m1_r) + ADDR_W'(m2_r);
      S_F_DIV1: begin
        if (div_done) begin
          if (div_quo >= ADDR_W'(active_r)) stat_nxt = ST_IGNORED;
          slab_nxt = div_quo[SLW-1:0];
        end
      end
      S_F_DIV2: begin
        if (div_done) begin
          if ((div_rem != '0) || (div_quo >= ADDR_W'(n_r))) stat_nxt = ST_IGNORED;
          slot_nxt = div_quo[NW-1:0];
        end
      end
      S_F_RD: if (!f_bit) stat_nxt = ST_IGNORED;
      S_DONE: begin
        if (out_ld) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_addr_nxt   = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // S_F_RD needs the read issued in S_F_DIV2 and reissues it to hold the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      os_r        <= OSIZE_RST;
      opb_r       <= OPB_RST;
      base_r      <= BASE_RST;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OSIZE: os_r   <= cfg_wdata[OSIZE_W-1:0];
          CFG_OPB:   opb_r  <= cfg_wdata[OPB_W-1:0];
          CFG_BASE:  base_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    words_r      <= words_nxt;
    n_r          <= n_nxt;
    prod_r       <= prod_nxt;
    stride_r     <= stride_nxt;
    s_r          <= s_nxt;
    w_r          <= w_nxt;
    cnt_r        <= cnt_nxt;
    slot_r       <= slot_nxt;
    slab_r       <= slab_nxt;
    m1_r         <= m1_nxt;
    m2_r         <= m2_nxt;
    res_r        <= res_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  sba_ram #(.WIDTH(WORD_W), .DEPTH(BD)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  sba_ram #(.WIDTH(NW), .DEPTH(MAX_SLABS)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  sba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= ACW'(MAX_SLABS))
    else $error("active slab count beyond pool");

  a_bm_with_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (bm_we && state_r != S_A_ACT) |-> cnt_we)
    else $error("bitmap update without count update");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_PREP)
    else $error("accepted item not started");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_F_START1 || state_r == S_F_START2))
    else $error("divider started outside free path");

endmodule
